FILE: src/ttpc_pkg.sv
// ----------------------------------------------------------------------------
// ttpc_pkg: shared definitions for the thermal throttle phase controller
// Widths, register map, cap action and poll class codes.
// ----------------------------------------------------------------------------
package ttpc_pkg;

   localparam int TEMP_WIDTH = 10;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int REG_IDX_WIDTH = 3;

   typedef logic [TEMP_WIDTH-1:0] temp_type;
   typedef logic [1:0] phase_type;

   // register index: byte address divided by four
   typedef enum logic [REG_IDX_WIDTH-1:0] {
      REG_SHUTDOWN   = 3'd0,
      REG_MAX_HIGH   = 3'd1,
      REG_MAX_LOW    = 3'd2,
      REG_MID_HIGH   = 3'd3,
      REG_MID_LOW    = 3'd4,
      REG_LOW_HIGH   = 3'd5,
      REG_LOW_LOW    = 3'd6
   } reg_idx_type;

   typedef enum logic [2:0] {
      CAP_NONE   = 3'd0,
      CAP_REMOVE = 3'd1,
      CAP_LOW    = 3'd2,
      CAP_MID    = 3'd3,
      CAP_MAX    = 3'd4
   } cap_type;

   typedef enum logic [1:0] {
      POLL_NORMAL = 2'd0,
      POLL_LOW    = 2'd1,
      POLL_FAST   = 2'd2
   } poll_type;

   localparam phase_type PHASE_OFF = 2'd0;
   localparam phase_type PHASE_LOW = 2'd1;
   localparam phase_type PHASE_MID = 2'd2;
   localparam phase_type PHASE_MAX = 2'd3;

   localparam temp_type RST_SHUTDOWN = TEMP_WIDTH'(110);
   localparam temp_type RST_MAX_HIGH = TEMP_WIDTH'(90);
   localparam temp_type RST_MAX_LOW  = TEMP_WIDTH'(85);
   localparam temp_type RST_MID_HIGH = TEMP_WIDTH'(80);
   localparam temp_type RST_MID_LOW  = TEMP_WIDTH'(75);
   localparam temp_type RST_LOW_HIGH = TEMP_WIDTH'(70);
   localparam temp_type RST_LOW_LOW  = TEMP_WIDTH'(65);

   function automatic poll_type poll_of(input phase_type phase);
      poll_type poll;
      case (phase)
         PHASE_OFF: poll = POLL_NORMAL;
         PHASE_LOW: poll = POLL_LOW;
         default:   poll = POLL_FAST;
      endcase
      return poll;
   endfunction

endpackage

FILE: src/thermal_throttle_phase_controller.sv
// ----------------------------------------------------------------------------
// thermal_throttle_phase_controller
// Multi-level thermal throttle with hysteresis: one sample in, one verdict out.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+----------------------------------
//  req      | in        | req_valid/req_stall  | temperature, sample_valid
//  rsp      | out       | rsp_valid/rsp_stall  | phase_now, cap_action, power_off,
//           |           |                      | poll_class
//  csr      | in/out    | psel/penable/pready  | seven threshold registers
//
//  A sample passes the input register, then the rule logic into the result
//  register. One beat per cycle is sustained while rsp is not stalled; the
//  phase register closes its loop through the rule logic.
//  Reset clears the phase to unthrottled, empties both stages and loads the
//  default thresholds. While a result is stalled the input register still takes
//  one more beat; req_stall rises only when both stages are full and rsp stalls.
//
module thermal_throttle_phase_controller (
   input  logic                                clock,
   input  logic                                reset,
   // sample channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ttpc_pkg::TEMP_WIDTH-1:0]     req_temperature,
   input  logic                                req_sample_valid,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_phase_now,
   output logic [2:0]                          rsp_cap_action,
   output logic                                rsp_power_off,
   output logic [1:0]                          rsp_poll_class,
   // register port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [ttpc_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [ttpc_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [ttpc_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                pready
);

   // threshold registers
   ttpc_pkg::temp_type shutdown_ff, max_high_ff, max_low_ff;
   ttpc_pkg::temp_type mid_high_ff, mid_low_ff, low_high_ff, low_low_ff;

   ttpc_pkg::reg_idx_type csr_idx;
   ttpc_pkg::temp_type    csr_wval;
   logic                  csr_write;

   // input stage
   logic               s1_valid_ff;
   ttpc_pkg::temp_type s1_temp_ff;
   logic               s1_sample_ff;

   // phase state and result register
   ttpc_pkg::phase_type phase_ff, phase_in;
   logic                out_valid_ff;
   ttpc_pkg::phase_type out_phase_ff;
   ttpc_pkg::cap_type   out_cap_ff, cap_in;
   logic                out_off_ff, off_in;
   ttpc_pkg::poll_type  out_poll_ff, poll_in;

   logic advance;
   logic req_take;

   // ---------------------------------------------------------------------
   // Register port: always ready, write lands on the access cycle.
   // ---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_idx   = ttpc_pkg::reg_idx_type'(paddr[ttpc_pkg::CSR_ADDR_WIDTH-1:2]);
   assign csr_wval  = pwdata[ttpc_pkg::TEMP_WIDTH-1:0];
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         shutdown_ff <= ttpc_pkg::RST_SHUTDOWN;
         max_high_ff <= ttpc_pkg::RST_MAX_HIGH;
         max_low_ff  <= ttpc_pkg::RST_MAX_LOW;
         mid_high_ff <= ttpc_pkg::RST_MID_HIGH;
         mid_low_ff  <= ttpc_pkg::RST_MID_LOW;
         low_high_ff <= ttpc_pkg::RST_LOW_HIGH;
         low_low_ff  <= ttpc_pkg::RST_LOW_LOW;
      end else if (csr_write) begin
         case (csr_idx)
            ttpc_pkg::REG_SHUTDOWN: shutdown_ff <= csr_wval;
            ttpc_pkg::REG_MAX_HIGH: max_high_ff <= csr_wval;
            ttpc_pkg::REG_MAX_LOW:  max_low_ff  <= csr_wval;
            ttpc_pkg::REG_MID_HIGH: mid_high_ff <= csr_wval;
            ttpc_pkg::REG_MID_LOW:  mid_low_ff  <= csr_wval;
            ttpc_pkg::REG_LOW_HIGH: low_high_ff <= csr_wval;
            ttpc_pkg::REG_LOW_LOW:  low_low_ff  <= csr_wval;
            default: ;  // drop writes past the register list
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         ttpc_pkg::REG_SHUTDOWN: prdata = ttpc_pkg::CSR_DATA_WIDTH'(shutdown_ff);
         ttpc_pkg::REG_MAX_HIGH: prdata = ttpc_pkg::CSR_DATA_WIDTH'(max_high_ff);
         ttpc_pkg::REG_MAX_LOW:  prdata = ttpc_pkg::CSR_DATA_WIDTH'(max_low_ff);
         ttpc_pkg::REG_MID_HIGH: prdata = ttpc_pkg::CSR_DATA_WIDTH'(mid_high_ff);
         ttpc_pkg::REG_MID_LOW:  prdata = ttpc_pkg::CSR_DATA_WIDTH'(mid_low_ff);
         ttpc_pkg::REG_LOW_HIGH: prdata = ttpc_pkg::CSR_DATA_WIDTH'(low_high_ff);
         ttpc_pkg::REG_LOW_LOW:  prdata = ttpc_pkg::CSR_DATA_WIDTH'(low_low_ff);
         default:                prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Flow control. The input stage moves on whenever the result register is
   // empty or being drained; it refills in the same cycle.
   // ---------------------------------------------------------------------
   assign advance   = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && out_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take || advance) begin
         s1_valid_ff <= req_take;
      end
   end

   // capture a beat into the input register
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_temp_ff   <= req_temperature;
         s1_sample_ff <= req_sample_valid;
      end
   end

   // ---------------------------------------------------------------------
   // Rule evaluation: six rules against the old phase, first match wins.
   // A failed read holds the phase and asks for the fast poll.
   // ---------------------------------------------------------------------
   always_comb begin
      logic ge_low_high, lt_low_low, ge_mid_high, lt_mid_low, ge_max_high, lt_max_low;
      ge_low_high = s1_temp_ff >= low_high_ff;
      lt_low_low  = s1_temp_ff <  low_low_ff;
      ge_mid_high = s1_temp_ff >= mid_high_ff;
      lt_mid_low  = s1_temp_ff <  mid_low_ff;
      ge_max_high = s1_temp_ff >= max_high_ff;
      lt_max_low  = s1_temp_ff <  max_low_ff;

      phase_in = phase_ff;
      cap_in   = ttpc_pkg::CAP_NONE;
      off_in   = 1'b0;
      poll_in  = ttpc_pkg::POLL_FAST;

      if (s1_sample_ff) begin
         off_in = s1_temp_ff >= shutdown_ff;
         if (ge_low_high && !ge_mid_high && phase_ff == ttpc_pkg::PHASE_OFF) begin
            cap_in   = ttpc_pkg::CAP_LOW;
            phase_in = ttpc_pkg::PHASE_LOW;
         end else if (lt_low_low && phase_ff != ttpc_pkg::PHASE_OFF) begin
            cap_in   = ttpc_pkg::CAP_REMOVE;
            phase_in = ttpc_pkg::PHASE_OFF;
         end else if (ge_mid_high && !ge_max_high && !phase_ff[1]) begin
            cap_in   = ttpc_pkg::CAP_MID;
            phase_in = ttpc_pkg::PHASE_MID;
         end else if (lt_mid_low && phase_ff[1]) begin
            cap_in   = ttpc_pkg::CAP_LOW;
            phase_in = ttpc_pkg::PHASE_LOW;
         end else if (ge_max_high) begin
            cap_in   = ttpc_pkg::CAP_MAX;
            phase_in = ttpc_pkg::PHASE_MAX;
         end else if (lt_max_low && phase_ff == ttpc_pkg::PHASE_MAX) begin
            cap_in   = ttpc_pkg::CAP_MID;
            phase_in = ttpc_pkg::PHASE_MID;
         end
         poll_in = ttpc_pkg::poll_of(phase_in);
      end
   end

   // commit the phase together with the result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ttpc_pkg::PHASE_OFF;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            phase_ff <= phase_in;
         end
         if (advance || !rsp_stall) begin
            out_valid_ff <= advance;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_phase_ff <= phase_in;
         out_cap_ff   <= cap_in;
         out_off_ff   <= off_in;
         out_poll_ff  <= poll_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_phase_now  = out_phase_ff;
   assign rsp_cap_action = out_cap_ff;
   assign rsp_power_off  = out_off_ff;
   assign rsp_poll_class = out_poll_ff;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   a_phase_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> phase_ff == $past(phase_ff))
      else $error("phase changed without a result beat");

   a_phase_match: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_phase_ff == phase_ff)
      else $error("result phase differs from held phase");

   a_remove_off: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_cap_ff == ttpc_pkg::CAP_REMOVE ||
                        out_poll_ff == ttpc_pkg::POLL_NORMAL))
      |-> out_phase_ff == ttpc_pkg::PHASE_OFF)
      else $error("unthrottled result with wrong phase");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && out_valid_ff))
      else $error("input stalled with a free stage");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: thermal throttle phase controller
// Drives temperature beats with random idle gaps and random result stalls,
// predicts each verdict from a local phase tracker, and programs the seven
// threshold registers between traffic phases (defaults, all-zero, all-ones,
// ordered ladders and scattered values).
// ----------------------------------------------------------------------------
module testbench;

   localparam int TEMP_MAX    = (1 << ttpc_pkg::TEMP_WIDTH) - 1;
   localparam int REG_COUNT   = 7;
   localparam int UNMAPPED_REG = 7;    // first index past the register map
   localparam int MAX_IDLE    = 12;
   localparam int TAIL_CYCLES = 8;     // two-stage pipe plus margin
   // ~1600 beats, each at worst a full send gap, a full stall and the pipe,
   // plus register traffic; taken several times over
   localparam int CYCLE_LIMIT = 400000;

   typedef enum {SET_ZERO, SET_FULL, SET_LADDER, SET_SCATTER} setting_kind_type;

   typedef struct packed {
      ttpc_pkg::phase_type phase;
      ttpc_pkg::cap_type   cap;
      logic                power_off;
      ttpc_pkg::poll_type  poll;
   } verdict_type;

   // Track the throttle phase and thresholds; queue one verdict per sample.
   class phase_tracker_type;
      ttpc_pkg::temp_type  threshold [REG_COUNT];
      ttpc_pkg::phase_type phase;
      verdict_type         due_verdicts [$];
      int                  errors;

      function new();
         threshold[ttpc_pkg::REG_SHUTDOWN] = ttpc_pkg::RST_SHUTDOWN;
         threshold[ttpc_pkg::REG_MAX_HIGH] = ttpc_pkg::RST_MAX_HIGH;
         threshold[ttpc_pkg::REG_MAX_LOW]  = ttpc_pkg::RST_MAX_LOW;
         threshold[ttpc_pkg::REG_MID_HIGH] = ttpc_pkg::RST_MID_HIGH;
         threshold[ttpc_pkg::REG_MID_LOW]  = ttpc_pkg::RST_MID_LOW;
         threshold[ttpc_pkg::REG_LOW_HIGH] = ttpc_pkg::RST_LOW_HIGH;
         threshold[ttpc_pkg::REG_LOW_LOW]  = ttpc_pkg::RST_LOW_LOW;
         phase  = ttpc_pkg::PHASE_OFF;
         errors = 0;
      endfunction

      function void set_threshold(int idx, logic [ttpc_pkg::CSR_DATA_WIDTH-1:0] value);
         if (idx < REG_COUNT) begin
            threshold[idx] = value[ttpc_pkg::TEMP_WIDTH-1:0];
         end
      endfunction

      function void take_sample(ttpc_pkg::temp_type t, logic ok);
         verdict_type         v;
         ttpc_pkg::phase_type np;
         v.cap       = ttpc_pkg::CAP_NONE;
         v.power_off = 1'b0;
         np          = phase;
         if (!ok) begin
            // failed read: hold the phase, ask for the fastest poll
            v.phase = phase;
            v.poll  = ttpc_pkg::POLL_FAST;
         end else begin
            if (t >= threshold[ttpc_pkg::REG_SHUTDOWN]) begin
               v.power_off = 1'b1;
            end
            // first matching rule wins, tested against the held phase
            if (t >= threshold[ttpc_pkg::REG_LOW_HIGH]
                && t < threshold[ttpc_pkg::REG_MID_HIGH]
                && phase == ttpc_pkg::PHASE_OFF) begin
               v.cap = ttpc_pkg::CAP_LOW;    np = ttpc_pkg::PHASE_LOW;
            end else if (t < threshold[ttpc_pkg::REG_LOW_LOW]
                         && phase != ttpc_pkg::PHASE_OFF) begin
               v.cap = ttpc_pkg::CAP_REMOVE; np = ttpc_pkg::PHASE_OFF;
            end else if (t >= threshold[ttpc_pkg::REG_MID_HIGH]
                         && t < threshold[ttpc_pkg::REG_MAX_HIGH]
                         && phase < ttpc_pkg::PHASE_MID) begin
               v.cap = ttpc_pkg::CAP_MID;    np = ttpc_pkg::PHASE_MID;
            end else if (t < threshold[ttpc_pkg::REG_MID_LOW]
                         && phase > ttpc_pkg::PHASE_LOW) begin
               v.cap = ttpc_pkg::CAP_LOW;    np = ttpc_pkg::PHASE_LOW;
            end else if (t >= threshold[ttpc_pkg::REG_MAX_HIGH]) begin
               v.cap = ttpc_pkg::CAP_MAX;    np = ttpc_pkg::PHASE_MAX;
            end else if (t < threshold[ttpc_pkg::REG_MAX_LOW]
                         && phase == ttpc_pkg::PHASE_MAX) begin
               v.cap = ttpc_pkg::CAP_MID;    np = ttpc_pkg::PHASE_MID;
            end
            phase   = np;
            v.phase = np;
            case (np)
               ttpc_pkg::PHASE_OFF: v.poll = ttpc_pkg::POLL_NORMAL;
               ttpc_pkg::PHASE_LOW: v.poll = ttpc_pkg::POLL_LOW;
               default:             v.poll = ttpc_pkg::POLL_FAST;
            endcase
         end
         due_verdicts.push_back(v);
      endfunction

      function void match_verdict(logic [1:0] phase_now, logic [2:0] cap_action,
                                  logic power_off, logic [1:0] poll_class);
         verdict_type v;
         if (due_verdicts.size() == 0) begin
            $display("%0t: verdict beat with none expected (phase %0d cap %0d)",
                     $time, phase_now, cap_action);
            errors++;
            return;
         end
         v = due_verdicts.pop_front();
         if (phase_now !== v.phase) begin
            $display("%0t: phase_now expected %0d actual %0d", $time, v.phase, phase_now);
            errors++;
         end
         if (cap_action !== v.cap) begin
            $display("%0t: cap_action expected %0d actual %0d", $time, v.cap, cap_action);
            errors++;
         end
         if (power_off !== v.power_off) begin
            $display("%0t: power_off expected %0d actual %0d", $time, v.power_off,
                     power_off);
            errors++;
         end
         if (poll_class !== v.poll) begin
            $display("%0t: poll_class expected %0d actual %0d", $time, v.poll, poll_class);
            errors++;
         end
      endfunction
   endclass

   // Clock, reset and every block input start at known values.
   logic                                clock            = 1'b0;
   logic                                reset            = 1'b1;
   logic                                req_valid        = 1'b0;
   logic                                req_stall;
   ttpc_pkg::temp_type                  req_temperature  = '0;
   logic                                req_sample_valid = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_stall        = 1'b0;
   logic [1:0]                          rsp_phase_now;
   logic [2:0]                          rsp_cap_action;
   logic                                rsp_power_off;
   logic [1:0]                          rsp_poll_class;
   logic                                psel             = 1'b0;
   logic                                penable          = 1'b0;
   logic                                pwrite           = 1'b0;
   logic [ttpc_pkg::CSR_ADDR_WIDTH-1:0] paddr            = '0;
   logic [ttpc_pkg::CSR_DATA_WIDTH-1:0] pwdata           = '0;
   logic [ttpc_pkg::CSR_DATA_WIDTH-1:0] prdata;
   logic                                pready;

   phase_tracker_type tracker     = new();
   int                sent_count  = 0;
   int                taken_count = 0;
   int                cycle_count = 0;

   thermal_throttle_phase_controller u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_temperature  (req_temperature),
      .req_sample_valid (req_sample_valid),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_phase_now    (rsp_phase_now),
      .rsp_cap_action   (rsp_cap_action),
      .rsp_power_off    (rsp_power_off),
      .rsp_poll_class   (rsp_poll_class),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Hard stop: a hung handshake or a lost beat ends up here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[thermal_throttle_phase_controller] ERROR");
         $finish;
      end
   end

   // Draw an idle count per beat; each side runs calm stretches with no idling,
   // on different periods so the two sides drift against each other.
   function automatic int idle_cycles(int n, int period, int calm);
      return (n % period < calm) ? 0 : int'($urandom_range(0, MAX_IDLE));
   endfunction

   // Result sink: check every accepted beat, then hold stall for a random count.
   always begin : verdict_sink
      int hold;
      @(posedge clock);
      if (!reset && rsp_valid && !rsp_stall) begin
         tracker.match_verdict(rsp_phase_now, rsp_cap_action, rsp_power_off,
                               rsp_poll_class);
         hold = idle_cycles(taken_count, 170, 35);
         taken_count++;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Send one sample beat. Drop valid only when a gap follows, so a
   // back-to-back beat keeps valid high without a same-step glitch.
   task automatic send_sample(input ttpc_pkg::temp_type t, input logic ok);
      int gap;
      gap = idle_cycles(sent_count, 200, 40);
      sent_count++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_temperature  <= t;
      req_sample_valid <= ok;
      do @(posedge clock); while (req_stall);
      tracker.take_sample(t, ok);
   endtask

   // Register write (setup, access), then read back mapped registers.
   task automatic write_threshold(input int idx,
                                  input logic [ttpc_pkg::CSR_DATA_WIDTH-1:0] value);
      logic [ttpc_pkg::CSR_DATA_WIDTH-1:0] expected;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ttpc_pkg::CSR_ADDR_WIDTH'(4 * idx);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      tracker.set_threshold(idx, value);
      if (idx < REG_COUNT) begin
         pwrite  <= 1'b0;
         penable <= 1'b0;
         @(posedge clock);
         penable <= 1'b1;
         do @(posedge clock); while (!pready);
         expected = ttpc_pkg::CSR_DATA_WIDTH'(tracker.threshold[idx]);
         if (prdata !== expected) begin
            $display("%0t: register %0d readback expected %0d actual %0d",
                     $time, idx, expected, prdata);
            tracker.errors++;
         end
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Lower valid and hold until every queued verdict has come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (tracker.due_verdicts.size() != 0) @(posedge clock);
   endtask

   task automatic program_thresholds(input setting_kind_type kind);
      int level;
      level = $urandom_range(0, 700);
      // index 6 is the lowest band edge, index 0 the shutdown point
      for (int i = REG_COUNT - 1; i >= 0; i--) begin
         case (kind)
            SET_ZERO:
               write_threshold(i, $urandom & ~ttpc_pkg::CSR_DATA_WIDTH'(TEMP_MAX));
            SET_FULL:
               write_threshold(i, $urandom | ttpc_pkg::CSR_DATA_WIDTH'(TEMP_MAX));
            SET_LADDER: begin
               write_threshold(i, level);
               level += $urandom_range(0, 45);
            end
            default:     write_threshold(i, $urandom);
         endcase
      end
   endtask

   // Random samples: mostly a slow temperature walk that wanders across band
   // edges, with jumps onto a threshold, uniform noise and failed reads.
   task automatic random_samples(input int count);
      int t;
      int pick;
      t = $urandom_range(0, TEMP_MAX);
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            send_sample(ttpc_pkg::temp_type'($urandom), 1'b0);
         end else begin
            if (pick < 3) begin
               t = $urandom_range(0, TEMP_MAX);
            end else if (pick < 7) begin
               t = int'(tracker.threshold[$urandom_range(0, REG_COUNT - 1)])
                   + int'($urandom_range(0, 4)) - 2;
            end else begin
               t = t + int'($urandom_range(0, 8)) - 4;
            end
            if (t < 0) t = 0;
            if (t > TEMP_MAX) t = TEMP_MAX;
            send_sample(ttpc_pkg::temp_type'(t), 1'b1);
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed walk through every rule at the reset thresholds
      // (shutdown 110, max 90/85, mid 80/75, low 70/65).
      send_sample(ttpc_pkg::temp_type'(TEMP_MAX), 1'b0);  // failed read while unthrottled
      send_sample(ttpc_pkg::temp_type'(0), 1'b1);         // cold: no change
      send_sample(ttpc_pkg::temp_type'(70), 1'b1);        // enter low cap
      send_sample(ttpc_pkg::temp_type'(69), 1'b1);        // inside low hysteresis: hold
      send_sample(ttpc_pkg::temp_type'(80), 1'b1);        // mid cap
      send_sample(ttpc_pkg::temp_type'(79), 1'b1);        // inside mid hysteresis: hold
      send_sample(ttpc_pkg::temp_type'(90), 1'b1);        // max cap
      send_sample(ttpc_pkg::temp_type'(TEMP_MAX), 1'b1);  // max cap again plus power off
      send_sample(ttpc_pkg::temp_type'(TEMP_MAX), 1'b0);  // failed read hides power off
      send_sample(ttpc_pkg::temp_type'(89), 1'b1);        // inside max hysteresis: hold
      send_sample(ttpc_pkg::temp_type'(84), 1'b1);        // fall back to mid
      send_sample(ttpc_pkg::temp_type'(74), 1'b1);        // fall back to low
      send_sample(ttpc_pkg::temp_type'(64), 1'b1);        // remove limit
      send_sample(ttpc_pkg::temp_type'(110), 1'b1);       // straight to max at shutdown
      send_sample(ttpc_pkg::temp_type'(109), 1'b1);       // just under shutdown
      send_sample(ttpc_pkg::temp_type'(0), 1'b1);         // remove wins over everything
      send_sample(ttpc_pkg::temp_type'(85), 1'b1);        // unthrottled straight to mid
      send_sample(ttpc_pkg::temp_type'(65), 1'b1);        // mid to low at the low edge
      send_sample(ttpc_pkg::temp_type'(341), 1'b1);       // alternating bit patterns
      send_sample(ttpc_pkg::temp_type'(682), 1'b1);
      send_sample(ttpc_pkg::temp_type'(512), 1'b0);
      send_sample(ttpc_pkg::temp_type'(1), 1'b1);
      random_samples(440);

      // Extremes: every band edge at zero, then at full scale; upper data
      // bits carry junk that the registers must drop.
      wait_idle();
      program_thresholds(SET_ZERO);
      random_samples(60);
      wait_idle();
      program_thresholds(SET_FULL);
      random_samples(60);

      // A write past the register map must change nothing.
      wait_idle();
      write_threshold(UNMAPPED_REG, $urandom);
      random_samples(20);

      // Ordered ladders with narrow hysteresis bands.
      for (int s = 0; s < 6; s++) begin
         wait_idle();
         program_thresholds(SET_LADDER);
         random_samples(120);
      end

      // Scattered thresholds: no ordering, rules apply literally.
      for (int s = 0; s < 3; s++) begin
         wait_idle();
         program_thresholds(SET_SCATTER);
         random_samples(80);
      end

      // Drain, then give stray beats a chance to show up.
      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.due_verdicts.size() == 0) begin
         $display("[thermal_throttle_phase_controller] OK");
      end else begin
         $display("[thermal_throttle_phase_controller] ERROR");
      end
      $finish;
   end

endmodule
